FILE: rtl/tbd_pkg.sv
// Shared types and constants for the time bucket downsampler.
// No dependencies.
package tbd_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_START = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_END   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUCKET_WIDTH = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AGG_MODE     = 8'd3;

    localparam logic       OP_SAMPLE = 1'b0;
    localparam logic       OP_FLUSH  = 1'b1;

    localparam logic [1:0] AGG_AVG  = 2'd0;
    localparam logic [1:0] AGG_MAX  = 2'd1;
    localparam logic [1:0] AGG_MIN  = 2'd2;
    localparam logic [1:0] AGG_LAST = 2'd3;

    localparam logic signed [63:0] RST_WINDOW_START = 64'sd0;
    localparam logic signed [63:0] RST_WINDOW_END   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0]        RST_BUCKET_WIDTH = 63'd1000000000;

    // classified item passed from front to back
    typedef struct packed {
        logic               op;
        logic [63:0]        offset;
        logic signed [31:0] value;
    } t_item;

    // back-end status for top-level checks
    typedef struct packed {
        logic load;
        logic final_flag;
        logic open;
    } t_back_stat;

endpackage

FILE: rtl/tbd_front.sv
// Front end: accepts items, drops samples outside the window or when the bucket width is zero, forms offsets.
// Depends on tbd_pkg.
module tbd_front (
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic signed [63:0]   i_sample_time,
    input  logic signed [31:0]   i_sample_value,
    input  logic signed [63:0]   i_window_start,
    input  logic signed [63:0]   i_window_end,
    input  logic [62:0]          i_bucket_width,
    input  logic                 i_q_full,
    output logic                 o_push,
    output tbd_pkg::t_item       o_item
);
    import tbd_pkg::*;

    logic drop;

    assign drop = (i_bucket_width == '0) || (i_sample_time < i_window_start)
                  || (i_sample_time > i_window_end);
    assign o_in_ready    = !i_q_full;
    assign o_push        = i_in_valid && !i_q_full && ((i_operation == OP_FLUSH) || !drop);
    assign o_item.op     = i_operation;
    assign o_item.offset = i_sample_time - i_window_start;
    assign o_item.value  = i_sample_value;

endmodule

FILE: rtl/tbd_fifo.sv
// Short item queue between the front and back ends.
// Depends on tbd_pkg.
module tbd_fifo #(
    parameter int DEPTH = tbd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  tbd_pkg::t_item             i_item,
    input  logic                       i_pop,
    output tbd_pkg::t_item             o_item,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import tbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        inc_ptr = (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= inc_ptr(r_wp);
            if (i_pop)  r_rp <= inc_ptr(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_item  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;

endmodule

FILE: rtl/tbd_div.sv
// Shared 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on tbd_pkg.
module tbd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    import tbd_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dsr;
    logic [64:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[63:0], r_quo[63]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign o_done = r_busy && r_cnt[6];
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy && !r_cnt[6]) begin
            r_rem <= ge ? rem_sh - {1'b0, r_dsr} : rem_sh;
            r_quo <= {r_quo[62:0], ge};
        end
    end

endmodule

FILE: rtl/tbd_back.sv
// Back end: bucket index, aggregation state, bucket close and result register.
// Depends on tbd_pkg and tbd_div.
module tbd_back #(
    parameter int COUNT_WIDTH = tbd_pkg::DEF_COUNT_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic signed [63:0]  i_window_start,
    input  logic [62:0]         i_bucket_width,
    input  logic [1:0]          i_agg_mode,
    input  logic                i_q_empty,
    input  tbd_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [63:0]  o_bkt_start,
    output logic signed [31:0]  o_bucket_value,
    output logic                o_final_bucket,
    output tbd_pkg::t_back_stat o_stat
);
    import tbd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_IDX  = 4'b0010,
        S_EMIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                   r_open;
    logic [63:0]            r_idx;
    logic signed [63:0]     r_sum;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic signed [31:0]     r_pick;
    logic signed [31:0]     r_val;
    logic [63:0]            r_new_idx;
    logic                   r_pend;
    logic                   r_final;
    logic [63:0]            r_macc, r_mcand, r_mplier;
    logic signed [31:0]     r_res;
    logic                   r_ovalid;
    logic signed [63:0]     r_ostart;
    logic signed [31:0]     r_oval;
    logic                   r_ofinal;

    logic               div_start, div_done;
    logic [63:0]        div_a, div_b, quo;
    logic [63:0]        sum_mag;
    logic [64:0]        sum_ext;
    logic signed [63:0] sum_add;
    logic               emit_go, out_load, add_now, add_fresh;
    logic signed [31:0] clamp_val;

    tbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign sum_mag = r_sum[63] ? 64'(-r_sum) : r_sum;
    assign sum_ext = {r_sum[63], r_sum} + {{33{r_val[31]}}, r_val};
    assign sum_add = (sum_ext[64] != sum_ext[63])
                     ? (sum_ext[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF)
                     : sum_ext[63:0];

    always_comb begin
        if (!r_sum[63])
            clamp_val = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
        else
            clamp_val = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quo[31:0]);
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_a     = sum_mag;
        div_b     = 64'(r_cnt);
        emit_go   = 1'b0;
        out_load  = 1'b0;
        add_now   = 1'b0;
        add_fresh = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_item.op == OP_FLUSH) begin
                        if (r_open) begin
                            emit_go   = 1'b1;
                            div_start = 1'b1;
                            n_state   = S_EMIT;
                        end
                    end else begin
                        div_start = 1'b1;
                        div_a     = i_item.offset;
                        div_b     = {1'b0, i_bucket_width};
                        n_state   = S_IDX;
                    end
                end
            end
            S_IDX: begin
                if (div_done) begin
                    if (!r_open) begin
                        add_fresh = 1'b1;
                        n_state   = S_IDLE;
                    end else if (quo == r_idx) begin
                        add_now = 1'b1;
                        n_state = S_IDLE;
                    end else if (quo < r_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        emit_go   = 1'b1;
                        div_start = 1'b1;
                        n_state   = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= 1'b0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_pick   <= '0;
            r_pend   <= 1'b0;
            r_final  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (r_state == S_IDLE && o_pop) begin
                r_val   <= i_item.value;
                r_final <= (i_item.op == OP_FLUSH);
                r_pend  <= 1'b0;
            end
            if (r_state == S_IDX && emit_go) begin
                r_pend    <= 1'b1;
                r_new_idx <= quo;
            end
            if (add_fresh) begin
                r_open <= 1'b1;
                r_idx  <= quo;
                r_sum  <= 64'(r_val);
                r_cnt  <= COUNT_WIDTH'(1);
                r_pick <= r_val;
            end
            if (add_now) begin
                r_sum <= sum_add;
                if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '0 || i_agg_mode == AGG_LAST)
                    r_pick <= r_val;
                else if (i_agg_mode == AGG_MAX && r_val > r_pick)
                    r_pick <= r_val;
                else if (i_agg_mode == AGG_MIN && r_val < r_pick)
                    r_pick <= r_val;
            end
            if (out_load) begin
                r_open   <= r_pend;
                r_idx    <= r_pend ? r_new_idx : '0;
                r_sum    <= r_pend ? 64'(r_val) : '0;
                r_cnt    <= r_pend ? COUNT_WIDTH'(1) : '0;
                r_pick   <= r_pend ? r_val : '0;
            end
        end
    end

    // serial shift-add for index * width, runs beside the average divide
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_macc   <= '0;
            r_mcand  <= {1'b0, i_bucket_width};
            r_mplier <= r_idx;
        end else if (r_state == S_EMIT) begin
            if (r_mplier[0]) r_macc <= r_macc + r_mcand;
            r_mcand  <= {r_mcand[62:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[63:1]};
        end
        if (r_state == S_EMIT && div_done)
            r_res <= (i_agg_mode == AGG_AVG) ? clamp_val : r_pick;
        if (out_load) begin
            r_ostart <= i_window_start + r_macc;
            r_oval   <= r_res;
            r_ofinal <= r_final;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_bkt_start     = r_ostart;
    assign o_bucket_value  = r_oval;
    assign o_final_bucket  = r_ofinal;
    assign o_stat.load       = out_load;
    assign o_stat.final_flag = r_final;
    assign o_stat.open       = r_open;

endmodule

FILE: rtl/time_bucket_downsampler.sv
// Time bucket downsampler: front classifier, item queue, divider-based back end.
// A result is valid once the sample that closes its bucket has passed the index divide
// and then the average divide, or once a flush has passed the average divide alone.
// The back end takes a new item only when it is done with the last one, and output stalls
// hold it; samples outside the window leave the front without entering the queue.
// Input accepts while the queue has room, so bursts of up to the queue depth are absorbed.
// Reset (synchronous, active low) restores register defaults and clears bucket state.
// Depends on tbd_pkg, tbd_front, tbd_fifo, tbd_div, tbd_back.
module time_bucket_downsampler #(
    parameter int COUNT_WIDTH = tbd_pkg::DEF_COUNT_WIDTH,
    parameter int QUEUE_DEPTH = tbd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbd_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [63:0]                          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic signed [63:0]                   i_sample_time,
    input  logic signed [31:0]                   i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [63:0]                   o_bkt_start,
    output logic signed [31:0]                   o_bucket_value,
    output logic                                 o_final_bucket
);
    import tbd_pkg::*;

    logic signed [63:0] r_window_start, r_window_end;
    logic [62:0]        r_bucket_width;
    logic [1:0]         r_agg_mode;

    logic       q_push, q_pop, q_empty, q_full;
    t_item      f_item, q_item;
    t_back_stat stat;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= RST_WINDOW_START;
            r_window_end   <= RST_WINDOW_END;
            r_bucket_width <= RST_BUCKET_WIDTH;
            r_agg_mode     <= AGG_AVG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW_START: r_window_start <= i_cfg_data;
                REG_WINDOW_END:   r_window_end   <= i_cfg_data;
                REG_BUCKET_WIDTH: r_bucket_width <= i_cfg_data[62:0];
                REG_AGG_MODE:     r_agg_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    tbd_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .i_window_start (r_window_start),
        .i_window_end   (r_window_end),
        .i_bucket_width (r_bucket_width),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_item         (f_item)
    );

    tbd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    tbd_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_start (r_window_start),
        .i_bucket_width (r_bucket_width),
        .i_agg_mode     (r_agg_mode),
        .i_q_empty      (q_empty),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bkt_start    (o_bkt_start),
        .o_bucket_value (o_bucket_value),
        .o_final_bucket (o_final_bucket),
        .o_stat         (stat)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.load |=> o_out_valid)
        else $error("result load without valid");

    a_flush_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.load && stat.final_flag) |=> !stat.open)
        else $error("bucket still open after flush");

endmodule
